// ===== rtl/nmea_pkg.sv =====
// Package for the NMEA sentence parser: phase and event codes, character constants,
// the result struct and the hex-digit and sentence-type helper functions.
// No dependencies.
`timescale 1ns / 1ps

package nmea_pkg;

  localparam int unsigned AddrMaxDefault = 8;
  localparam int unsigned DataMaxDefault = 80;

  localparam int unsigned CountWidth = 7;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperC = 8'h43;

  localparam logic [31:0] PrefixGpgg = 32'h4750_4747;
  localparam logic [31:0] PrefixGpgs = 32'h4750_4753;
  localparam logic [31:0] PrefixGprm = 32'h4750_524D;

  localparam logic [CountWidth-1:0] TypeMinLen = 7'd5;

  typedef enum logic [2:0] {
    PhWait = 3'd0,
    PhAddr = 3'd1,
    PhData = 3'd2,
    PhHex1 = 3'd3,
    PhHex2 = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EvNone  = 3'd0,
    EvStart = 3'd1,
    EvType  = 3'd2,
    EvChar  = 3'd3,
    EvEnd   = 3'd4,
    EvOk    = 3'd5,
    EvWrong = 3'd6,
    EvDrop  = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    KindGga  = 2'd0,
    KindGsa  = 2'd1,
    KindRmc  = 2'd2,
    KindNone = 2'd3
  } kind_e;

  typedef struct packed {
    event_e                event_res;
    logic [1:0]            sentence_kind;
    logic [7:0]            data_char;
    logic [CountWidth-1:0] data_position;
    logic [7:0]            computed_sum;
    logic [7:0]            received_sum;
  } result_t;

  // Decimal digits map directly; anything else is treated as a letter digit.
  function automatic logic [3:0] hex_nibble(input logic [7:0] b);
    logic [7:0] t;
    begin
      t = b - ChUpperA + 8'd10;
      if (b >= ChZero && b <= ChNine) begin
        hex_nibble = 4'(b - ChZero);
      end else begin
        hex_nibble = t[3:0];
      end
    end
  endfunction

  function automatic kind_e match_kind(input logic [31:0] last4, input logic [7:0] b);
    begin
      if (last4 == PrefixGpgg && b == ChUpperA) begin
        match_kind = KindGga;
      end else if (last4 == PrefixGpgs && b == ChUpperA) begin
        match_kind = KindGsa;
      end else if (last4 == PrefixGprm && b == ChUpperC) begin
        match_kind = KindRmc;
      end else begin
        match_kind = KindNone;
      end
    end
  endfunction

endpackage

// ===== rtl/nmea_in_if.sv =====
// Input channel of the NMEA sentence parser: one received byte with its overrun flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface nmea_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       overrun;

  modport source (output valid, output rx_byte, output overrun, input ready);
  modport sink (input valid, input rx_byte, input overrun, output ready);
endinterface

// ===== rtl/nmea_out_if.sv =====
// Result channel of the NMEA sentence parser: one event record per received byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface nmea_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [1:0] sentence_kind;
  logic [7:0] data_char;
  logic [6:0] data_position;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (
    output valid, output event_res, output sentence_kind, output data_char,
    output data_position, output computed_sum, output received_sum, input ready
  );
  modport sink (
    input valid, input event_res, input sentence_kind, input data_char,
    input data_position, input computed_sum, input received_sum, output ready
  );
endinterface

// ===== rtl/nmea_fsm.sv =====
// Sentence state machine of the NMEA parser: holds the parse state and computes the
// event record for the byte being transferred. Depends on nmea_pkg.
`timescale 1ns / 1ps

module nmea_fsm #(
  parameter int unsigned ADDR_MAX = nmea_pkg::AddrMaxDefault,
  parameter int unsigned DATA_MAX = nmea_pkg::DataMaxDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               overrun_i,
  output nmea_pkg::result_t  res_o
);

  localparam logic [nmea_pkg::CountWidth-1:0] AddrLimit = nmea_pkg::CountWidth'(ADDR_MAX);
  localparam logic [nmea_pkg::CountWidth-1:0] DataLimit = nmea_pkg::CountWidth'(DATA_MAX);

  nmea_pkg::phase_e                  phase_q, phase_d;
  logic [nmea_pkg::CountWidth-1:0]   count_q, count_d;
  logic [7:0]                        sum_q, sum_d;
  logic [7:0]                        high_q, high_d;
  logic [31:0]                       recent_q, recent_d;
  nmea_pkg::kind_e                   kind_q, kind_d;

  logic [nmea_pkg::CountWidth-1:0]   count_inc;
  nmea_pkg::kind_e                   kind_hit;
  logic [7:0]                        rsum;

  assign count_inc = count_q + 1'b1;
  assign kind_hit  = nmea_pkg::match_kind(recent_q, rx_byte_i);
  assign rsum      = {high_q[7:4], nmea_pkg::hex_nibble(rx_byte_i)};

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    sum_d    = sum_q;
    high_d   = high_q;
    recent_d = recent_q;
    kind_d   = kind_q;
    if (overrun_i) begin
      phase_d = nmea_pkg::PhWait;
    end else begin
      case (phase_q)
        nmea_pkg::PhWait: begin
          if (rx_byte_i == nmea_pkg::ChDollar) begin
            count_d  = '0;
            sum_d    = '0;
            recent_d = '0;
            kind_d   = nmea_pkg::KindNone;
            phase_d  = nmea_pkg::PhAddr;
          end
        end
        nmea_pkg::PhAddr: begin
          if (rx_byte_i != nmea_pkg::ChComma) begin
            if (count_q < AddrLimit) begin
              count_d  = count_inc;
              if (count_inc >= nmea_pkg::TypeMinLen && kind_hit < kind_q) begin
                kind_d = kind_hit;
              end
              recent_d = {recent_q[23:0], rx_byte_i};
              sum_d    = sum_q ^ rx_byte_i;
            end else begin
              phase_d = nmea_pkg::PhWait;
            end
          end else begin
            sum_d = sum_q ^ rx_byte_i;
            if (kind_q != nmea_pkg::KindNone) begin
              count_d = '0;
              phase_d = nmea_pkg::PhData;
            end else begin
              phase_d = nmea_pkg::PhWait;
            end
          end
        end
        nmea_pkg::PhData: begin
          if (rx_byte_i != nmea_pkg::ChStar) begin
            if (count_q < DataLimit) begin
              count_d = count_inc;
              sum_d   = sum_q ^ rx_byte_i;
            end else begin
              phase_d = nmea_pkg::PhWait;
            end
          end else begin
            phase_d = nmea_pkg::PhHex1;
          end
        end
        nmea_pkg::PhHex1: begin
          high_d  = {nmea_pkg::hex_nibble(rx_byte_i), 4'h0};
          phase_d = nmea_pkg::PhHex2;
        end
        nmea_pkg::PhHex2: begin
          high_d  = rsum;
          phase_d = nmea_pkg::PhWait;
        end
        default: begin
          phase_d = nmea_pkg::PhWait;
        end
      endcase
    end
  end

  // Event record for the current byte.
  always_comb begin
    res_o = '0;
    res_o.event_res = nmea_pkg::EvNone;
    if (overrun_i) begin
      if (phase_q != nmea_pkg::PhWait) begin
        res_o.event_res = nmea_pkg::EvDrop;
      end
    end else begin
      case (phase_q)
        nmea_pkg::PhWait: begin
          if (rx_byte_i == nmea_pkg::ChDollar) begin
            res_o.event_res = nmea_pkg::EvStart;
          end
        end
        nmea_pkg::PhAddr: begin
          if (rx_byte_i != nmea_pkg::ChComma) begin
            if (count_q >= AddrLimit) begin
              res_o.event_res = nmea_pkg::EvDrop;
            end
          end else if (kind_q != nmea_pkg::KindNone) begin
            res_o.event_res     = nmea_pkg::EvType;
            res_o.sentence_kind = kind_q;
          end else begin
            res_o.event_res = nmea_pkg::EvDrop;
          end
        end
        nmea_pkg::PhData: begin
          if (rx_byte_i != nmea_pkg::ChStar) begin
            if (count_q < DataLimit) begin
              res_o.event_res     = nmea_pkg::EvChar;
              res_o.sentence_kind = kind_q;
              res_o.data_char     = rx_byte_i;
              res_o.data_position = count_q;
            end else begin
              res_o.event_res = nmea_pkg::EvDrop;
            end
          end else begin
            res_o.event_res     = nmea_pkg::EvEnd;
            res_o.sentence_kind = kind_q;
            res_o.data_position = count_q;
          end
        end
        nmea_pkg::PhHex2: begin
          res_o.sentence_kind = kind_q;
          res_o.computed_sum  = sum_q;
          res_o.received_sum  = rsum;
          res_o.event_res     = (sum_q == rsum) ? nmea_pkg::EvOk : nmea_pkg::EvWrong;
        end
        default: begin
          res_o.event_res = nmea_pkg::EvNone;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= nmea_pkg::PhWait;
      count_q  <= '0;
      sum_q    <= '0;
      high_q   <= '0;
      recent_q <= '0;
      kind_q   <= nmea_pkg::KindNone;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      high_q   <= high_d;
      recent_q <= recent_d;
      kind_q   <= kind_d;
    end
  end

endmodule

// ===== rtl/nmea_sentence_parser.sv =====
// The parser takes one received serial byte per transfer and returns exactly one event
// record for it. A byte is taken in every clock cycle while the input is ready; its record
// appears in the output register in the cycle after the transfer. The input is ready whenever
// the output register is empty or is being read in the same cycle, so a stalled sink holds
// at most one record. Depends on nmea_pkg, nmea_in_if, nmea_out_if and nmea_fsm.
`timescale 1ns / 1ps

module nmea_sentence_parser #(
  parameter int unsigned ADDR_MAX = nmea_pkg::AddrMaxDefault,
  parameter int unsigned DATA_MAX = nmea_pkg::DataMaxDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nmea_in_if.sink    rx_i,
  nmea_out_if.source res_o
);

  logic              accept;
  nmea_pkg::result_t step_res;
  nmea_pkg::result_t res_q;
  logic              res_valid_q, res_valid_d;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  nmea_fsm #(
    .ADDR_MAX (ADDR_MAX),
    .DATA_MAX (DATA_MAX)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .rx_byte_i (rx_i.rx_byte),
    .overrun_i (rx_i.overrun),
    .res_o     (step_res)
  );

  assign res_valid_d = accept || (res_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.event_res     = res_q.event_res;
  assign res_o.sentence_kind = res_q.sentence_kind;
  assign res_o.data_char     = res_q.data_char;
  assign res_o.data_position = res_q.data_position;
  assign res_o.computed_sum  = res_q.computed_sum;
  assign res_o.received_sum  = res_q.received_sum;

endmodule

// ===== rtl/nmea_checker.sv =====
// Port-level checks for the NMEA sentence parser, attached to the top level by bind.
// Depends on nmea_pkg and nmea_sentence_parser.
`timescale 1ns / 1ps

module nmea_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       overrun_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] event_res_i,
  input logic [1:0] sentence_kind_i,
  input logic [7:0] data_char_i,
  input logic [7:0] computed_sum_i,
  input logic [7:0] received_sum_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_res_i))
    else $error("result changed while stalled");

  a_transfer_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && overrun_i |=> out_valid_i &&
      (event_res_i == nmea_pkg::EvNone || event_res_i == nmea_pkg::EvDrop))
    else $error("overrun byte did not give a none or drop record");

  a_sum_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_res_i == nmea_pkg::EvOk || event_res_i == nmea_pkg::EvWrong) |->
      ((computed_sum_i == received_sum_i) == (event_res_i == nmea_pkg::EvOk)))
    else $error("checksum verdict disagrees with the sums");

  a_side_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sentence_kind_i != nmea_pkg::KindNone &&
      (data_char_i == 8'h00 || event_res_i == nmea_pkg::EvChar))
    else $error("record fields inconsistent with event");

endmodule

bind nmea_sentence_parser nmea_checker u_nmea_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (rx_i.valid),
  .in_ready_i      (rx_i.ready),
  .overrun_i       (rx_i.overrun),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .event_res_i     (res_o.event_res),
  .sentence_kind_i (res_o.sentence_kind),
  .data_char_i     (res_o.data_char),
  .computed_sum_i  (res_o.computed_sum),
  .received_sum_i  (res_o.received_sum)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for nmea_sentence_parser: sends well-formed, broken and noise byte
// streams and checks every event record against a cycle-free model of the sentence parser.
// Depends on nmea_pkg, nmea_in_if, nmea_out_if and the RTL of nmea_sentence_parser.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned AddrLimit = nmea_pkg::AddrMaxDefault;
  localparam int unsigned DataLimit = nmea_pkg::DataMaxDefault;
  localparam int ItemTarget = 850;
  localparam int HoldCycles = 200;
  localparam int StallLimit = 1000;
  localparam int TailCycles = 8;
  localparam logic [7:0] ChLowerA = 8'h61;

  typedef logic [7:0] byte_list_t[$];
  typedef enum int {SumUpper, SumLower, SumFlipped, SumRaw} sum_style_e;

  class sentence_checker;
    nmea_pkg::phase_e  ph;
    logic [6:0]        count;
    logic [7:0]        xsum;
    logic [7:0]        hex_hi;
    logic [31:0]       tail;
    nmea_pkg::kind_e   kind;
    nmea_pkg::result_t awaited[$];
    int unsigned       errors;

    function new();
      ph = nmea_pkg::PhWait;
      count = '0;
      xsum = '0;
      hex_hi = '0;
      tail = '0;
      kind = nmea_pkg::KindNone;
      errors = 0;
    endfunction

    // Letters map so that 'A' and 'a' give ten; other bytes wrap the same way.
    function logic [3:0] digit_value(logic [7:0] c);
      if (c >= nmea_pkg::ChZero && c <= nmea_pkg::ChNine) begin
        return c[3:0];
      end
      return c[3:0] + 4'd9;
    endfunction

    function void note_byte(logic [7:0] b, logic ovr);
      nmea_pkg::result_t r;
      nmea_pkg::kind_e   k;
      r = '0;
      if (ovr) begin
        if (ph != nmea_pkg::PhWait) begin
          r.event_res = nmea_pkg::EvDrop;
        end
        ph = nmea_pkg::PhWait;
      end else begin
        case (ph)
          nmea_pkg::PhWait: begin
            if (b == nmea_pkg::ChDollar) begin
              count = '0;
              xsum = '0;
              tail = '0;
              kind = nmea_pkg::KindNone;
              ph = nmea_pkg::PhAddr;
              r.event_res = nmea_pkg::EvStart;
            end
          end
          nmea_pkg::PhAddr: begin
            if (b != nmea_pkg::ChComma) begin
              if (count < AddrLimit) begin
                count = count + 7'd1;
                if (count >= nmea_pkg::TypeMinLen) begin
                  k = nmea_pkg::KindNone;
                  if (tail == nmea_pkg::PrefixGpgg && b == nmea_pkg::ChUpperA) begin
                    k = nmea_pkg::KindGga;
                  end else if (tail == nmea_pkg::PrefixGpgs && b == nmea_pkg::ChUpperA) begin
                    k = nmea_pkg::KindGsa;
                  end else if (tail == nmea_pkg::PrefixGprm && b == nmea_pkg::ChUpperC) begin
                    k = nmea_pkg::KindRmc;
                  end
                  if (k < kind) begin
                    kind = k;
                  end
                end
                tail = {tail[23:0], b};
                xsum ^= b;
              end else begin
                ph = nmea_pkg::PhWait;
                r.event_res = nmea_pkg::EvDrop;
              end
            end else begin
              xsum ^= b;
              if (kind != nmea_pkg::KindNone) begin
                count = '0;
                ph = nmea_pkg::PhData;
                r.event_res = nmea_pkg::EvType;
                r.sentence_kind = kind;
              end else begin
                ph = nmea_pkg::PhWait;
                r.event_res = nmea_pkg::EvDrop;
              end
            end
          end
          nmea_pkg::PhData: begin
            if (b != nmea_pkg::ChStar) begin
              if (count < DataLimit) begin
                r.event_res = nmea_pkg::EvChar;
                r.sentence_kind = kind;
                r.data_char = b;
                r.data_position = count;
                count = count + 7'd1;
                xsum ^= b;
              end else begin
                ph = nmea_pkg::PhWait;
                r.event_res = nmea_pkg::EvDrop;
              end
            end else begin
              r.event_res = nmea_pkg::EvEnd;
              r.sentence_kind = kind;
              r.data_position = count;
              ph = nmea_pkg::PhHex1;
            end
          end
          nmea_pkg::PhHex1: begin
            hex_hi = {digit_value(b), 4'h0};
            ph = nmea_pkg::PhHex2;
          end
          nmea_pkg::PhHex2: begin
            hex_hi[3:0] = digit_value(b);
            r.sentence_kind = kind;
            r.computed_sum = xsum;
            r.received_sum = hex_hi;
            r.event_res = (xsum == hex_hi) ? nmea_pkg::EvOk : nmea_pkg::EvWrong;
            ph = nmea_pkg::PhWait;
          end
          default: begin
            ph = nmea_pkg::PhWait;
          end
        endcase
      end
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(nmea_pkg::result_t got);
      nmea_pkg::result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: record with no byte pending, event expected none actual %0d",
                 $time, got.event_res);
        return;
      end
      want = awaited.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("sentence_kind", want.sentence_kind, got.sentence_kind);
      compare_field("data_char", want.data_char, got.data_char);
      compare_field("data_position", want.data_position, got.data_position);
      compare_field("computed_sum", want.computed_sum, got.computed_sum);
      compare_field("received_sum", want.received_sum, got.received_sum);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  nmea_in_if  rx_if ();
  nmea_out_if res_if ();

  nmea_sentence_parser #(
    .ADDR_MAX(AddrLimit),
    .DATA_MAX(DataLimit)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  sentence_checker   ledger;
  nmea_pkg::result_t seen;
  int                bytes_sent = 0;
  int                quiet_cycles = 0;
  bit                idle_on = 1'b1;
  bit                hold_request = 1'b0;
  string             type_names[3] = '{"GPGGA", "GPGSA", "GPRMC"};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) < 16) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 50);
  endfunction

  function automatic byte_list_t text_bytes(string s);
    byte_list_t q;
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
    return q;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) begin
      return nmea_pkg::ChZero + 8'(n);
    end
    return (lower ? ChLowerA : nmea_pkg::ChUpperA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == nmea_pkg::ChComma || c == nmea_pkg::ChStar) begin
      c = nmea_pkg::ChDollar;
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_byte(input logic [7:0] b, input logic ovr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.overrun <= ovr;
    do begin
      @(posedge clk_i);
    end while (!rx_if.ready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic push_queue(input byte_list_t q);
    foreach (q[i]) begin
      push_byte(q[i], 1'b0);
    end
  endtask

  task automatic push_sentence(input byte_list_t addr, input byte_list_t body,
                               input sum_style_e style);
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    sum = nmea_pkg::ChComma;
    foreach (addr[i]) sum ^= addr[i];
    foreach (body[i]) sum ^= body[i];
    if (style == SumFlipped) begin
      sum ^= 8'($urandom_range(1, 255));
    end
    hi = hex_char(sum[7:4], style == SumLower);
    lo = hex_char(sum[3:0], style == SumLower);
    if (style == SumRaw) begin
      hi = 8'($urandom);
      lo = 8'($urandom);
    end
    push_byte(nmea_pkg::ChDollar, 1'b0);
    push_queue(addr);
    push_byte(nmea_pkg::ChComma, 1'b0);
    push_queue(body);
    push_byte(nmea_pkg::ChStar, 1'b0);
    push_byte(hi, 1'b0);
    push_byte(lo, 1'b0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        ledger.note_byte(rx_if.rx_byte, rx_if.overrun);
      end
      if (res_if.valid && res_if.ready) begin
        seen.event_res = nmea_pkg::event_e'(res_if.event_res);
        seen.sentence_kind = res_if.sentence_kind;
        seen.data_char = res_if.data_char;
        seen.data_position = res_if.data_position;
        seen.computed_sum = res_if.computed_sum;
        seen.received_sum = res_if.received_sum;
        ledger.check_result(seen);
      end
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Result sink: random back-pressure, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        stall = HoldCycles;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        stall = gap_len() - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    byte_list_t addr;
    byte_list_t body;
    byte_list_t partial;
    int         len;
    int         cut;
    int         pick;
    int         noise_bytes;
    int         long_count;
    bit         hold_done;
    sum_style_e style;

    ledger = new();
    noise_bytes = 0;
    long_count = 0;
    hold_done = 1'b0;
    rst_ni = 1'b0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    rx_if.overrun = 1'b0;
    res_if.ready = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Overrun while idle, a stray byte, a '$' in the data with a lowercase sum,
    // a zero data byte with arbitrary sum digits, an empty address and an overrun mid-address.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_sentence(text_bytes("GPRMC"), text_bytes("$"), SumLower);
    body = {8'h00};
    push_sentence(text_bytes("GPGSA"), body, SumRaw);
    push_queue(text_bytes("$,"));
    push_queue(text_bytes("$G"));
    push_byte(8'hFF, 1'b1);

    while (bytes_sent - noise_bytes < ItemTarget) begin
      if (!hold_done && bytes_sent >= 250) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      idle_on = !(bytes_sent >= 450 && bytes_sent < 570);
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        addr = {};
        repeat ($urandom_range(0, 3)) addr.push_back(plain_byte());
        addr = {addr, text_bytes(type_names[$urandom_range(0, 2)])};
        if ($urandom_range(0, 14) == 0) begin
          len = 79 + long_count % 3;
          long_count++;
        end else begin
          len = $urandom_range(0, 12);
        end
        body = {};
        repeat (len) body.push_back(plain_byte());
        case ($urandom_range(0, 19))
          0, 1, 2:  style = SumFlipped;
          3, 4:     style = SumRaw;
          5, 6, 7:  style = SumLower;
          default:  style = SumUpper;
        endcase
        push_sentence(addr, body, style);
      end else if (pick < 17) begin
        case ($urandom_range(0, 3))
          0: begin
            push_byte(nmea_pkg::ChDollar, 1'b0);
            repeat ($urandom_range(9, 12)) push_byte(plain_byte(), 1'b0);
          end
          1: begin
            push_byte(nmea_pkg::ChDollar, 1'b0);
            repeat ($urandom_range(0, 8)) push_byte(plain_byte(), 1'b0);
            push_byte(nmea_pkg::ChComma, 1'b0);
          end
          2: begin
            partial = {nmea_pkg::ChDollar};
            partial = {partial, text_bytes(type_names[$urandom_range(0, 2)]),
                       nmea_pkg::ChComma};
            repeat ($urandom_range(0, 4)) partial.push_back(plain_byte());
            cut = $urandom_range(1, partial.size());
            for (int i = 0; i < cut; i++) begin
              push_byte(partial[i], 1'b0);
            end
            push_byte(8'($urandom), 1'b1);
          end
          default: begin
            // A type split across a resync must not match.
            push_queue(text_bytes("$GPGG"));
            push_byte(8'($urandom), 1'b1);
            push_queue(text_bytes("$A,"));
          end
        endcase
      end else begin
        len = $urandom_range(1, 6);
        noise_bytes += len;
        repeat (len) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
    idle_on = 1'b1;
    rx_if.valid <= 1'b0;

    while (ledger.awaited.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
